FILE: hw/rtl/acef_pkg.sv
// ----------------------------------------------------------------------------
// acef_pkg
// Shared types and byte codes for the ANSI color escape filter.
// ----------------------------------------------------------------------------
`default_nettype none

package acef_pkg;

  // byte codes
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBRK = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRK = 8'h5D;  // ']'
  localparam logic [7:0] CH_M    = 8'h6D;  // 'm'
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_NUL  = 8'h00;

  // color codes at or above this value are stripped
  localparam int unsigned COLOR_LIMIT = 30;
  // saturating field value: at most 29*10+9
  localparam int unsigned MAG_W = 9;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_FSTART
  } ptr_op_e;

  typedef enum logic [2:0] {
    EMIT_BYTE,
    EMIT_ESC,
    EMIT_LBRK,
    EMIT_SEMI,
    EMIT_DATA
  } emit_sel_e;

  typedef struct packed {
    logic      load_byte;
    logic      store_byte;
    logic      clr_count;
    ptr_op_e   ptr_op;
    logic      fstart_next;
    logic      atoi_clr;
    logic      atoi_step;
    logic      set_fend;
    logic      fend_count;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
  } acef_cmd_t;

  typedef struct packed {
    logic byte_esc;
    logic byte_lbrk;
    logic byte_rbrk;
    logic byte_m;
    logic byte_letter;
    logic count_full;
    logic eot;
    logic at_semi;
    logic field_empty;
    logic field_kept;
    logic copy_stop;
    logic term_eot;
    logic slot;
  } acef_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ansi_color_escape_filter.sv
// ----------------------------------------------------------------------------
// ansi_color_escape_filter
// Terminal byte stream filter that strips color codes from SGR sequences.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------
//  in      | sink      | in_valid_i / in_stall_o    | in_byte_i
//  out     | source    | out_valid_o / out_stall_i  | out_byte_o, last_of_run_o
//  cfg     | APB slave | psel/penable/pwrite/pready | pass_through at 0x0
//
//  An accepted byte is registered, decoded in S_EVAL, then its output beats
//  are emitted one at a time; the input stays stalled until that is done.
//  A sequence end walks the parameter RAM (registered read): it scans each
//  byte and emits the prefix and the bytes of each kept field.
//  One output register holds a beat under out_stall_i while the next input
//  beat is taken; a stall only pauses the walk. Reset clears mode, count and
//  pass_through; the parameter RAM needs no clearing pass.
//
`default_nettype none

module ansi_color_escape_filter #(
  parameter int unsigned PARAM_DEPTH = 24
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input byte channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  in_byte_i,
  // output byte channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import acef_pkg::*;

  localparam int unsigned AW = $clog2(PARAM_DEPTH);

  acef_cmd_t    cmd;
  acef_status_t status;

  logic          pass_q;
  logic          cfg_wr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // register file: pass_through is the only register, word 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {31'd0, pass_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= 1'b0;
    end else if (cfg_wr) begin
      pass_q <= pwdata[0];
    end
  end

  acef_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pass_through_i (pass_q),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  acef_datapath #(
    .PARAM_DEPTH (PARAM_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (in_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  // collected CSI parameter bytes
  acef_ram #(
    .WIDTH (8),
    .DEPTH (PARAM_DEPTH)
  ) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/acef_ram.sv
// ----------------------------------------------------------------------------
// acef_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 24
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/acef_datapath.sv
// ----------------------------------------------------------------------------
// acef_datapath
// Byte register, parameter counters and pointers, field value scanner and
// output register of the ANSI color escape filter.
// ----------------------------------------------------------------------------
`default_nettype none

module acef_datapath #(
  parameter int unsigned PARAM_DEPTH = 24
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [7:0]                   in_byte_i,
  input  acef_pkg::acef_cmd_t          cmd_i,
  output acef_pkg::acef_status_t       status_o,
  output logic                         ram_we_o,
  output logic [$clog2(PARAM_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic [$clog2(PARAM_DEPTH)-1:0] ram_raddr_o,
  input  wire  [7:0]                   ram_rdata_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [7:0]                   out_byte_o,
  output logic                         last_of_run_o
);

  import acef_pkg::*;

  localparam int unsigned AW = $clog2(PARAM_DEPTH);
  localparam int unsigned CW = $clog2(PARAM_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(PARAM_DEPTH);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGIT,
    PH_STOP
  } atoi_ph_e;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  logic [7:0]       byte_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    fstart_q, fstart_d;
  logic [CW-1:0]    fend_q;
  logic             term_eot_q;
  atoi_ph_e         ph_q, ph_d;
  logic             neg_q, neg_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             last_q;

  logic             eot;
  logic             slot;
  logic             load_out;
  logic [7:0]       emit_byte;
  logic             mag_small;
  logic [MAG_W-1:0] mag_next;

  assign eot       = (ptr_q >= count_q) || (ram_rdata_i == CH_NUL);
  assign slot      = !out_valid_q || !out_stall_i;
  assign load_out  = cmd_i.emit && slot;
  assign mag_small = mag_q < MAG_W'(COLOR_LIMIT);
  // mag*10 + digit, only taken while mag is below the limit
  assign mag_next  = {mag_q[MAG_W-4:0], 3'b000} + {mag_q[MAG_W-2:0], 1'b0}
                   + {{(MAG_W-4){1'b0}}, ram_rdata_i[3:0]};

  always_comb begin
    status_o.byte_esc    = byte_q == CH_ESC;
    status_o.byte_lbrk   = byte_q == CH_LBRK;
    status_o.byte_rbrk   = byte_q == CH_RBRK;
    status_o.byte_m      = byte_q == CH_M;
    status_o.byte_letter = is_letter(byte_q);
    status_o.count_full  = count_q >= DEPTH_C;
    status_o.eot         = eot;
    status_o.at_semi     = ram_rdata_i == CH_SEMI;
    status_o.field_empty = ptr_q == fstart_q;
    status_o.field_kept  = neg_q || mag_small;
    status_o.copy_stop   = (ptr_q == fend_q) || eot;
    status_o.term_eot    = term_eot_q;
    status_o.slot        = slot;
  end

  // pointer into the parameter store; the RAM reads at its next value
  always_comb begin
    case (cmd_i.ptr_op)
      PTR_ZERO:   ptr_d = '0;
      PTR_INC:    ptr_d = ptr_q + CW'(1);
      PTR_FSTART: ptr_d = fstart_q;
      default:    ptr_d = ptr_q;
    endcase
    if (cmd_i.ptr_op == PTR_ZERO) begin
      fstart_d = '0;
    end else if (cmd_i.fstart_next) begin
      fstart_d = ptr_q + CW'(1);
    end else begin
      fstart_d = fstart_q;
    end
  end

  assign ram_raddr_o = (ptr_d >= DEPTH_C) ? '0 : ptr_d[AW-1:0];
  assign ram_we_o    = cmd_i.store_byte;
  assign ram_waddr_o = count_q[AW-1:0];
  assign ram_wdata_o = byte_q;

  always_comb begin
    if (cmd_i.clr_count) begin
      count_d = '0;
    end else if (cmd_i.store_byte) begin
      count_d = count_q + CW'(1);
    end else begin
      count_d = count_q;
    end
  end

  // field value scan: spaces, one sign, then digits
  always_comb begin
    ph_d  = ph_q;
    neg_d = neg_q;
    mag_d = mag_q;
    if (cmd_i.atoi_clr) begin
      ph_d  = PH_LEAD;
      neg_d = 1'b0;
      mag_d = '0;
    end else if (cmd_i.atoi_step) begin
      case (ph_q)
        PH_LEAD: begin
          if (is_space(ram_rdata_i)) begin
            ph_d = PH_LEAD;
          end else if (ram_rdata_i == CH_PLUS || ram_rdata_i == CH_MINUS) begin
            neg_d = ram_rdata_i == CH_MINUS;
            ph_d  = PH_DIGIT;
          end else if (is_digit(ram_rdata_i)) begin
            if (mag_small) mag_d = mag_next;
            ph_d = PH_DIGIT;
          end else begin
            ph_d = PH_STOP;
          end
        end
        PH_DIGIT: begin
          if (is_digit(ram_rdata_i)) begin
            if (mag_small) mag_d = mag_next;
          end else begin
            ph_d = PH_STOP;
          end
        end
        default: ph_d = ph_q;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.emit_sel)
      EMIT_ESC:  emit_byte = CH_ESC;
      EMIT_LBRK: emit_byte = CH_LBRK;
      EMIT_SEMI: emit_byte = CH_SEMI;
      EMIT_DATA: emit_byte = ram_rdata_i;
      default:   emit_byte = byte_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      fstart_q    <= '0;
      fend_q      <= '0;
      term_eot_q  <= 1'b0;
      ph_q        <= PH_LEAD;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      fstart_q <= fstart_d;
      ph_q     <= ph_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
      if (cmd_i.set_fend) begin
        fend_q     <= ptr_q;
        term_eot_q <= eot;
      end else if (cmd_i.fend_count) begin
        fend_q <= count_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      byte_q <= in_byte_i;
    end
    if (load_out) begin
      out_byte_q <= emit_byte;
      last_q     <= cmd_i.emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("parameter count past store depth");

  a_field_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstart_q <= ptr_q)
    else $error("field start ahead of read pointer");

endmodule

`default_nettype wire

FILE: hw/rtl/acef_ctrl.sv
// ----------------------------------------------------------------------------
// acef_ctrl
// Sequencer of the ANSI color escape filter: parse mode, input handshake and
// the rewrite walk over the parameter store.
// ----------------------------------------------------------------------------
`default_nettype none

module acef_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire                     pass_through_i,
  input  acef_pkg::acef_status_t  status_i,
  output acef_pkg::acef_cmd_t     cmd_o
);

  import acef_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_X_ESC,
    S_CHECK,
    S_PRE_ESC,
    S_PRE_BRK,
    S_PRE_SEMI,
    S_SCAN,
    S_COPY,
    S_FINAL
  } state_e;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic   any_kept_q, any_kept_d;
  logic   color_q, color_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    any_kept_d = any_kept_q;
    color_d    = color_q;
    cmd_o      = '0;
    cmd_o.ptr_op   = PTR_HOLD;
    cmd_o.emit_sel = EMIT_BYTE;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (pass_through_i) begin
          state_d = S_FINAL;
        end else begin
          unique case (mode_q)
            MODE_ESC: begin
              if (status_i.byte_lbrk) begin
                mode_d = MODE_CSI;
                cmd_o.clr_count = 1'b1;
                state_d = S_IDLE;
              end else begin
                mode_d  = MODE_TEXT;
                state_d = S_X_ESC;
              end
            end
            MODE_CSI: begin
              if (!status_i.byte_m && !status_i.count_full && !status_i.byte_letter) begin
                cmd_o.store_byte = 1'b1;
                state_d = S_IDLE;
              end else begin
                mode_d         = MODE_TEXT;
                cmd_o.ptr_op   = PTR_ZERO;
                cmd_o.atoi_clr = 1'b1;
                any_kept_d     = 1'b0;
                if (status_i.byte_m) begin
                  color_d = 1'b1;
                  state_d = S_SCAN;
                end else begin
                  color_d          = 1'b0;
                  cmd_o.fend_count = 1'b1;
                  state_d          = S_CHECK;
                end
              end
            end
            default: begin
              if (status_i.byte_esc) begin
                mode_d  = MODE_ESC;
                state_d = S_IDLE;
              end else begin
                mode_d  = MODE_TEXT;
                state_d = S_FINAL;
              end
            end
          endcase
        end
      end
      S_X_ESC: begin
        // ESC then the byte, or ESC alone when the byte is ']'
        cmd_o.emit      = 1'b1;
        cmd_o.emit_sel  = EMIT_ESC;
        cmd_o.emit_last = status_i.byte_rbrk;
        if (status_i.slot) begin
          state_d = status_i.byte_rbrk ? S_IDLE : S_FINAL;
        end
      end
      S_CHECK: begin
        state_d = status_i.eot ? S_IDLE : S_PRE_ESC;
      end
      S_PRE_ESC: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = EMIT_ESC;
        if (status_i.slot) state_d = S_PRE_BRK;
      end
      S_PRE_BRK: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = EMIT_LBRK;
        if (status_i.slot) begin
          cmd_o.ptr_op = PTR_FSTART;
          any_kept_d   = 1'b1;
          state_d      = S_COPY;
        end
      end
      S_PRE_SEMI: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = EMIT_SEMI;
        if (status_i.slot) begin
          cmd_o.ptr_op = PTR_FSTART;
          state_d      = S_COPY;
        end
      end
      S_SCAN: begin
        if (status_i.eot || status_i.at_semi) begin
          if (!status_i.field_empty && status_i.field_kept) begin
            cmd_o.set_fend = 1'b1;
            state_d = any_kept_q ? S_PRE_SEMI : S_PRE_ESC;
          end else if (status_i.eot) begin
            state_d = any_kept_q ? S_FINAL : S_IDLE;
          end else begin
            cmd_o.ptr_op      = PTR_INC;
            cmd_o.fstart_next = 1'b1;
            cmd_o.atoi_clr    = 1'b1;
          end
        end else begin
          cmd_o.atoi_step = 1'b1;
          cmd_o.ptr_op    = PTR_INC;
        end
      end
      S_COPY: begin
        if (status_i.copy_stop) begin
          if (color_q && !status_i.term_eot) begin
            cmd_o.ptr_op      = PTR_INC;
            cmd_o.fstart_next = 1'b1;
            cmd_o.atoi_clr    = 1'b1;
            state_d           = S_SCAN;
          end else begin
            state_d = S_FINAL;
          end
        end else begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_DATA;
          if (status_i.slot) cmd_o.ptr_op = PTR_INC;
        end
      end
      S_FINAL: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_sel  = EMIT_BYTE;
        cmd_o.emit_last = 1'b1;
        if (status_i.slot) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= MODE_TEXT;
      any_kept_q <= 1'b0;
      color_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      any_kept_q <= any_kept_d;
      color_q    <= color_d;
    end
  end

  a_accept_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_EVAL)
    else $error("accepted beat not evaluated next cycle");

  a_brk_after_esc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRE_BRK) |->
      ($past(state_q) == S_PRE_ESC || $past(state_q) == S_PRE_BRK))
    else $error("'[' prefix without ESC");

endmodule

`default_nettype wire
